@@ rtl/rftl_pkg.sv @@
// Shared types and constants for the ring finger table lookup unit.
// No dependencies.
`default_nettype none

package rftl_pkg;

    localparam int ID_W   = 64;
    localparam int ADDR_W = 48;

    localparam logic [ID_W-1:0] ALL_ONES = '1;

    // action codes
    localparam logic [1:0] ACT_PRED   = 2'd0;
    localparam logic [1:0] ACT_SUCC   = 2'd1;
    localparam logic [1:0] ACT_INSERT = 2'd2;
    localparam logic [1:0] ACT_REMOVE = 2'd3;

    // configuration register indexes
    localparam logic [0:0] REG_SELF_ID   = 1'b0;
    localparam logic [0:0] REG_SELF_ADDR = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr;
    } finger_t;

    typedef struct packed {
        logic shift;   // take neighbor's entry
        logic load;    // refill with self
    } cell_ctrl_t;

    typedef struct packed {
        logic clear;   // new item: reset best distance
        logic step;    // evaluate head entry this cycle
    } eval_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/rftl_cell.sv @@
// One finger entry of the rotating table.
// Depends on rftl_pkg.
`default_nettype none

module rftl_cell
    import rftl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire finger_t    load_entry,
    input  wire finger_t    nbr_entry,
    output finger_t         entry
);

    finger_t entry_reg;
    finger_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = load_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = nbr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

@@ rtl/rftl_eval.sv @@
// Head-of-ring evaluation: distance compare for queries, write-back for
// insert and remove. Depends on rftl_pkg.
`default_nettype none

module rftl_eval
    import rftl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire eval_ctrl_t        ctrl,
    input  wire logic [1:0]        action,
    input  wire logic [ID_W-1:0]   key,
    input  wire logic [ADDR_W-1:0] node_addr,
    input  wire logic [ID_W-1:0]   self_id,
    input  wire logic [ADDR_W-1:0] self_addr,
    input  wire logic [5:0]        step,
    input  wire finger_t           head,
    output finger_t                wb_entry,
    output finger_t                best,
    output logic [ID_W-1:0]        best_dist
);

    logic [ID_W-1:0] dist_reg;
    logic [ID_W-1:0] dist_next;
    finger_t         best_reg;
    finger_t         best_next;

    logic            id_gt_key;
    logic            id_eq_key;
    logic [ID_W-1:0] ring_dist;
    logic            cand;
    logic [ID_W-1:0] span_start;
    logic            in_span;
    logic            ins_hit;

    assign id_gt_key = head.id > key;
    assign id_eq_key = head.id == key;

    // wrapped distances lose one more
    always_comb
    begin
        ring_dist = '0;
        cand      = 1'b0;
        case (action)
            ACT_PRED:
            begin
                ring_dist = key - head.id - ID_W'(id_gt_key);
                cand      = 1'b1;
            end
            ACT_SUCC:
            begin
                ring_dist = head.id - key - ID_W'(!id_gt_key);
                cand      = !id_eq_key;
            end
            default:
            begin
                ring_dist = '0;
                cand      = 1'b0;
            end
        endcase
    end

    assign span_start = self_id + (ID_W'(1) << step);

    always_comb
    begin
        if (span_start < head.id)
        begin
            in_span = (key > span_start) && (key < head.id);
        end
        else if (span_start > head.id)
        begin
            in_span = (key > span_start) || (key < head.id);
        end
        else
        begin
            in_span = key != span_start;
        end
    end

    assign ins_hit = (key == span_start) || in_span;

    always_comb
    begin
        wb_entry = head;
        if (ctrl.step && (action == ACT_INSERT) && ins_hit)
        begin
            wb_entry.id   = key;
            wb_entry.addr = node_addr;
        end
        else if (ctrl.step && (action == ACT_REMOVE) && id_eq_key)
        begin
            wb_entry.id   = self_id;
            wb_entry.addr = self_addr;
        end
    end

    // strict compare keeps the lowest index on ties
    always_comb
    begin
        dist_next = dist_reg;
        best_next = best_reg;
        if (ctrl.clear)
        begin
            dist_next = ALL_ONES;
        end
        else if (ctrl.step && cand && (ring_dist < dist_reg))
        begin
            dist_next = ring_dist;
            best_next = head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= ALL_ONES;
        end
        else
        begin
            dist_reg <= dist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    assign best      = best_reg;
    assign best_dist = dist_reg;

endmodule

`default_nettype wire

@@ rtl/ring_finger_table_lookup_unit.sv @@
// Ring finger table lookup unit: FINGERS entries held in a ring of cells.
// Steps: accept the item, rotate the ring so that every finger passes the
// head evaluator, then finish; a query finishes once the output register is
// free; its result is registered and shown the cycle after. A new item is
// taken only once the last is done, set by the single head evaluator.
// Reset: asynchronous, active low; all fingers and self registers clear to 0.
`default_nettype none

module ring_finger_table_lookup_unit
    import rftl_pkg::*;
#(
    parameter int FINGERS = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input items
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        action,
    input  wire logic [ID_W-1:0]   key,
    input  wire logic [ADDR_W-1:0] node_addr,
    // result items
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [ID_W-1:0]        found_id,
    output logic [ADDR_W-1:0]      found_addr,
    output logic                   is_self,
    // configuration writes
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [ID_W-1:0]   cfg_data
);

    localparam int CW = (FINGERS > 1) ? $clog2(FINGERS) : 1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     step_reg, step_next;
    logic [1:0]        action_reg;
    logic [ID_W-1:0]   key_reg;
    logic [ADDR_W-1:0] naddr_reg;
    logic [ID_W-1:0]   self_id_reg;
    logic [ADDR_W-1:0] self_addr_reg;

    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_self_reg;

    logic              in_take;
    logic              cfg_take;
    logic              is_query;
    logic              out_free;
    logic              out_load;

    finger_t           load_entry;
    finger_t           wb_entry;
    finger_t           best;
    logic [ID_W-1:0]   best_dist;
    finger_t           cell_q [FINGERS];
    cell_ctrl_t        cell_ctrl;
    eval_ctrl_t        eval_ctrl;

    assign in_stall  = state_reg != S_IDLE;
    assign cfg_ready = state_reg == S_IDLE;
    assign in_take   = in_valid && !in_stall;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign is_query  = (action_reg == ACT_PRED) || (action_reg == ACT_SUCC);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == S_DONE) && is_query && out_free;

    // ---------------------------------------------------------------
    // Sequencer: accept, rotate the ring once, then finish (a query delivers).
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_SCAN;
                    step_next  = '0;
                end
            end
            S_SCAN:
            begin
                step_next = step_reg + CW'(1);
                if (step_reg == CW'(FINGERS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // a query waits here until the output register frees up
                if (!is_query || out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // item payload capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= action;
            key_reg    <= key;
            naddr_reg  <= node_addr;
        end
    end

    // ---------------------------------------------------------------
    // Self registers; any write also refills every cell of the ring with self.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg   <= '0;
            self_addr_reg <= '0;
        end
        else if (cfg_take)
        begin
            case (cfg_index)
                REG_SELF_ID:   self_id_reg   <= cfg_data;
                REG_SELF_ADDR: self_addr_reg <= cfg_data[ADDR_W-1:0];
                default:       self_id_reg   <= self_id_reg;
            endcase
        end
    end

    always_comb
    begin
        load_entry.id   = self_id_reg;
        load_entry.addr = self_addr_reg;
        case (cfg_index)
            REG_SELF_ID:   load_entry.id   = cfg_data;
            REG_SELF_ADDR: load_entry.addr = cfg_data[ADDR_W-1:0];
            default:       load_entry.id   = self_id_reg;
        endcase
    end

    // ---------------------------------------------------------------
    // Ring of cells. Each scan cycle the ring shifts toward cell 0; the
    // head (cell 0) goes through the evaluator and re-enters at the tail,
    // so once the scan is over every finger is back at its own index.
    // At scan step s the head holds finger s.
    // ---------------------------------------------------------------
    assign cell_ctrl.shift = state_reg == S_SCAN;
    assign cell_ctrl.load  = cfg_take;

    for (genvar k = 0; k < FINGERS; k++)
    begin : g_cell
        finger_t nbr;
        if (k == FINGERS - 1)
        begin : g_tail
            assign nbr = wb_entry;
        end
        else
        begin : g_mid
            assign nbr = cell_q[k+1];
        end

        rftl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .load_entry (load_entry),
            .nbr_entry  (nbr),
            .entry      (cell_q[k])
        );
    end

    assign eval_ctrl.clear = in_take;
    assign eval_ctrl.step  = state_reg == S_SCAN;

    rftl_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (eval_ctrl),
        .action    (action_reg),
        .key       (key_reg),
        .node_addr (naddr_reg),
        .self_id   (self_id_reg),
        .self_addr (self_addr_reg),
        .step      (6'(step_reg)),
        .head      (cell_q[0]),
        .wb_entry  (wb_entry),
        .best      (best),
        .best_dist (best_dist)
    );

    // ---------------------------------------------------------------
    // Output register. A best distance still at all-ones means no finger
    // was chosen, so self is returned.
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_self_reg <= best_dist == ALL_ONES;
            if (best_dist == ALL_ONES)
            begin
                out_id_reg   <= self_id_reg;
                out_addr_reg <= self_addr_reg;
            end
            else
            begin
                out_id_reg   <= best.id;
                out_addr_reg <= best.addr;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign found_id   = out_id_reg;
    assign found_addr = out_addr_reg;
    assign is_self    = out_self_reg;

endmodule

`default_nettype wire

@@ rtl/rftl_checker.sv @@
// Port-level checks for ring_finger_table_lookup_unit, bound to the top level.
// Depends on rftl_pkg.
`default_nettype none

module rftl_checker
    import rftl_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [ID_W-1:0]   found_id,
    input wire logic              cfg_ready
);

    // an accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block took no busy cycle after an item");

    // config port is open exactly when items are
    a_cfg_vs_in: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready != in_stall)
        else $error("config ready and input stall disagree");

    // a new result only appears at the end of a scan
    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a scan");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(found_id)))
        else $error("stalled result changed");

endmodule

bind ring_finger_table_lookup_unit rftl_checker u_rftl_checker (.*);

`default_nettype wire
